>>> design/prompt_hash_bias_generator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the prompt hash bias generator
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PROMPT_HASH_BIAS_GENERATOR_MACROS_SVH
`define PROMPT_HASH_BIAS_GENERATOR_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every edge outside reset
`define PHBG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define PHBG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PHBG_ASSERT(lbl, clk, rst, prop, msg)
`define PHBG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> design/phbg_pkg.sv
// ----------------------------------------------------------------------------
// phbg_pkg
// Types, constants and hash helpers shared by the bias generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package phbg_pkg;

  // Hash and mixer constants
  localparam logic [63:0] FNV_BASIS  = 64'h1465_0FB0_739D_0383;
  localparam logic [63:0] XS_MULT    = 64'h2545_F491_4F6C_DD1D;
  localparam logic [23:0] UNIT_FULL  = 24'hFF_FFFF;
  localparam logic [22:0] UNIT_HALF  = 23'h7F_FFFF;
  localparam logic [23:0] Q_MAX      = 24'h7F_FFFF;
  localparam logic [23:0] Q_OVER     = 24'h80_0000;
  localparam logic [23:0] SCALE_RESET = 24'h01_0000;

  // Register map
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_BIAS_SCALE = 1'b0;

  // Input selector codes
  localparam logic [1:0] FUNC_RESTART = 2'd0;
  localparam logic [1:0] FUNC_ABSORB  = 2'd1;
  localparam logic [1:0] FUNC_EMIT    = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] prompt_byte;
  } req_item_t;

  typedef struct packed {
    logic signed [23:0] bias_value;
    logic [23:0]        unit_raw;
  } res_item_t;

  // Queued command after classification
  typedef enum logic [1:0] {
    OP_RESTART,
    OP_ABSORB,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL0,
    BK_MUL1,
    BK_MUL2,
    BK_MSUM,
    BK_CENTER,
    BK_SCALE,
    BK_ABS,
    BK_DIV,
    BK_DONE
  } back_state_t;

  // xorshift64 step with shifts 12, 25, 27
  function automatic logic [63:0] xorshift(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s >> 12);
    t = t ^ (t << 25);
    t = t ^ (t >> 27);
    return t;
  endfunction

  // Multiply by the FNV prime 2^40 + 0x1B3 as a sparse shift-add
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

`default_nettype wire

>>> design/phbg_front.sv
// ----------------------------------------------------------------------------
// phbg_front
// Accepts input items, drops unused selectors and queues the rest as commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "prompt_hash_bias_generator_macros.svh"

module phbg_front #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_ready,
  input  phbg_pkg::req_item_t req_data,
  output logic                cmd_valid,
  input  wire                 cmd_ready,
  output phbg_pkg::cmd_t      cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  phbg_pkg::cmd_t   entries [DEPTH];
  phbg_pkg::cmd_t   cmd_in;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             keep;
  logic             push;
  logic             pop;

  // Classify: the unused selector is accepted and dropped
  always_comb begin
    keep        = (req_data.func != phbg_pkg::FUNC_NONE);
    cmd_in.data = req_data.prompt_byte;
    unique case (req_data.func)
      phbg_pkg::FUNC_RESTART: cmd_in.op = phbg_pkg::OP_RESTART;
      phbg_pkg::FUNC_ABSORB:  cmd_in.op = phbg_pkg::OP_ABSORB;
      default:                cmd_in.op = phbg_pkg::OP_EMIT;
    endcase
  end

  assign req_ready = (count != CNT_W'(DEPTH));
  assign push      = req_valid && req_ready && keep;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = entries[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `PHBG_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue count over depth")
  `PHBG_ASSERT_NEXT(a_drop_unused, clk, rst, req_valid && req_ready && !keep && !pop, $stable(count), "dropped item changed queue")

endmodule

`default_nettype wire

>>> design/phbg_back.sv
// ----------------------------------------------------------------------------
// phbg_back
// Executes queued commands: hash update, output mixing, scaling and rounding.
// ----------------------------------------------------------------------------
`default_nettype none
`include "prompt_hash_bias_generator_macros.svh"

module phbg_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmd_valid,
  output logic                cmd_ready,
  input  phbg_pkg::cmd_t      cmd,
  input  wire [23:0]          bias_scale,
  output logic                res_valid,
  input  wire                 res_ready,
  output phbg_pkg::res_item_t res_data
);

  phbg_pkg::back_state_t state;
  phbg_pkg::back_state_t state_next;

  logic [63:0]        hash_state;
  logic [63:0]        mix_s;
  logic [63:0]        acc;
  logic [63:0]        prod;
  logic signed [25:0] centred;
  logic [23:0]        unit;
  logic               neg;
  logic [47:0]        mag_n;
  logic [23:0]        quo;

  logic               pop;
  logic               res_free;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic [23:0]        div_hi;
  logic [23:0]        div_lo;
  logic [24:0]        div_sum;
  logic [47:0]        abs_val;

  assign cmd_ready = (state == phbg_pkg::BK_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign res_free  = !res_valid || res_ready;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      phbg_pkg::BK_MUL0: begin
        mul_a = {1'b0, mix_s[31:0]};
        mul_b = {1'b0, phbg_pkg::XS_MULT[31:0]};
      end
      phbg_pkg::BK_MUL1: begin
        mul_a = {1'b0, mix_s[31:0]};
        mul_b = {1'b0, phbg_pkg::XS_MULT[63:32]};
      end
      phbg_pkg::BK_MUL2: begin
        mul_a = {1'b0, mix_s[63:32]};
        mul_b = {1'b0, phbg_pkg::XS_MULT[31:0]};
      end
      phbg_pkg::BK_SCALE: begin
        mul_a = {{7{centred[25]}}, centred};
        mul_b = {{9{bias_scale[23]}}, bias_scale};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Rounding helpers: magnitude plus half, then divide by 2^24-1 with one fixup
  assign abs_val = prod[63] ? ~prod[47:0] : prod[47:0];
  assign div_hi  = mag_n[47:24];
  assign div_lo  = mag_n[23:0];
  assign div_sum = {1'b0, div_hi} + {1'b0, div_lo};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      phbg_pkg::BK_IDLE: begin
        if (pop && cmd.op == phbg_pkg::OP_EMIT) begin
          state_next = phbg_pkg::BK_MUL0;
        end
      end
      phbg_pkg::BK_MUL0:   state_next = phbg_pkg::BK_MUL1;
      phbg_pkg::BK_MUL1:   state_next = phbg_pkg::BK_MUL2;
      phbg_pkg::BK_MUL2:   state_next = phbg_pkg::BK_MSUM;
      phbg_pkg::BK_MSUM:   state_next = phbg_pkg::BK_CENTER;
      phbg_pkg::BK_CENTER: state_next = phbg_pkg::BK_SCALE;
      phbg_pkg::BK_SCALE:  state_next = phbg_pkg::BK_ABS;
      phbg_pkg::BK_ABS:    state_next = phbg_pkg::BK_DIV;
      phbg_pkg::BK_DIV:    state_next = phbg_pkg::BK_DONE;
      phbg_pkg::BK_DONE: begin
        if (res_free) begin
          state_next = phbg_pkg::BK_IDLE;
        end
      end
      default: state_next = phbg_pkg::BK_IDLE;
    endcase
  end

  // Control state, hash state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= phbg_pkg::BK_IDLE;
      hash_state <= phbg_pkg::FNV_BASIS;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        unique case (cmd.op)
          phbg_pkg::OP_RESTART: hash_state <= phbg_pkg::FNV_BASIS;
          phbg_pkg::OP_ABSORB:
            hash_state <= phbg_pkg::fnv_mul(hash_state ^ {56'h0, cmd.data});
          phbg_pkg::OP_EMIT:    hash_state <= phbg_pkg::xorshift(hash_state);
          default:              hash_state <= hash_state;
        endcase
      end
      if (state == phbg_pkg::BK_DONE && res_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      phbg_pkg::BK_IDLE: begin
        mix_s <= phbg_pkg::xorshift(hash_state);
      end
      phbg_pkg::BK_MUL0: begin
        prod <= mul_p[63:0];
      end
      phbg_pkg::BK_MUL1: begin
        prod <= mul_p[63:0];
        acc  <= prod;
      end
      phbg_pkg::BK_MUL2: begin
        prod <= mul_p[63:0];
        acc  <= acc + {prod[31:0], 32'h0};
      end
      phbg_pkg::BK_MSUM: begin
        acc <= acc + {prod[31:0], 32'h0};
      end
      phbg_pkg::BK_CENTER: begin
        unit    <= acc[63:40];
        centred <= {1'b0, acc[63:40], 1'b0} - {2'b00, phbg_pkg::UNIT_FULL};
      end
      phbg_pkg::BK_SCALE: begin
        prod <= mul_p[63:0];
      end
      phbg_pkg::BK_ABS: begin
        neg   <= prod[63];
        mag_n <= abs_val + (prod[63] ? 48'({phbg_pkg::UNIT_HALF} + 23'd0) + 48'd1
                                     : 48'(phbg_pkg::UNIT_HALF));
      end
      phbg_pkg::BK_DIV: begin
        quo <= div_hi + {23'h0, (div_sum >= {1'b0, phbg_pkg::UNIT_FULL})};
      end
      phbg_pkg::BK_DONE: begin
        if (res_free) begin
          res_data.unit_raw <= unit;
          if (neg) begin
            res_data.bias_value <= -quo;
          end else if (quo == phbg_pkg::Q_OVER) begin
            res_data.bias_value <= phbg_pkg::Q_MAX;
          end else begin
            res_data.bias_value <= quo;
          end
        end
      end
      default: begin
        mix_s <= mix_s;
      end
    endcase
  end

  `PHBG_ASSERT_NEXT(a_hash_hold, clk, rst, state != phbg_pkg::BK_IDLE, $stable(hash_state), "hash changed while busy")
  `PHBG_ASSERT_NEXT(a_quo_bound, clk, rst, state == phbg_pkg::BK_DIV, quo <= phbg_pkg::Q_OVER, "quotient out of range")
  `PHBG_ASSERT_NEXT(a_result_load, clk, rst, state == phbg_pkg::BK_DONE && res_free, res_valid && state == phbg_pkg::BK_IDLE, "result not loaded")

endmodule

`default_nettype wire

>>> design/prompt_hash_bias_generator.sv
// ----------------------------------------------------------------------------
// prompt_hash_bias_generator
// FNV-1a prompt hash seeding an xorshift64* stream of scaled Q8.16 biases.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_data) takes items with a selector:
//   restart the hash, absorb one prompt byte, or emit one bias. Items with the
//   unused selector are taken and dropped. Each emit item gives one item on
//   the result channel (res_valid/res_ready/res_data): the Q8.16 bias and the
//   24-bit unit it came from. Restart and absorb give no result.
//   A small command queue sits between intake and execution, so requests are
//   taken while the execution unit works or a result waits to be taken.
//   Restart and absorb update the hash as they leave the queue. An emit
//   occupies the execution unit through three 32x32 partial products of the
//   mixer on one shared multiplier, scaling and a rounding division; the
//   unit takes no further command until the emit's result is loaded into
//   the result register, while the queue goes on taking requests.
//   A stalled receiver holds the result register; the queue then fills and
//   req_ready drops. Reset sets the hash to the FNV_BASIS constant and
//   bias_scale (APB offset 0) to 1.0. Write bias_scale only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module prompt_hash_bias_generator #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              req_valid,
  output logic                             req_ready,
  input  phbg_pkg::req_item_t              req_data,
  output logic                             res_valid,
  input  wire                              res_ready,
  output phbg_pkg::res_item_t              res_data,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [phbg_pkg::ADDR_W-1:0]       paddr,
  input  wire [31:0]                       pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic [23:0]    bias_scale;
  logic           reg_hit;
  logic           cmd_valid;
  logic           cmd_ready;
  phbg_pkg::cmd_t cmd;

  // Register file
  assign pready  = 1'b1;
  assign reg_hit = (paddr[phbg_pkg::ADDR_W-1:2] == phbg_pkg::REG_BIAS_SCALE);
  assign prdata  = reg_hit ? {{8{bias_scale[23]}}, bias_scale} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_scale <= phbg_pkg::SCALE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      bias_scale <= pwdata[23:0];
    end
  end

  // Intake and command queue
  phbg_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  // Execution unit with result register
  phbg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .bias_scale(bias_scale),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire

>>> sim/prompt_hash_bias_generator_test.sv
// ----------------------------------------------------------------------------
// prompt_hash_bias_generator_test
// Self-checking bench for the prompt hash bias generator. Sends restart,
// absorb and emit items, and items with the unused selector. Programs
// bias_scale over APB while the block is idle. A scoreboard follows the hash
// and the scale, and checks each emitted bias and unit in order. Both sides
// draw random gaps, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module prompt_hash_bias_generator_test;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_ITEMS  = 650;
  localparam int RANDOM_PHASES = 5;
  localparam int MAX_GAP       = 17;
  localparam logic [23:0] SCALE_MAX = 24'h7F_FFFF;
  localparam logic [23:0] SCALE_MIN = 24'h80_0000;
  localparam logic [phbg_pkg::ADDR_W-1:0] SCALE_ADDR = {phbg_pkg::REG_BIAS_SCALE, 2'b00};

  // Tracks the hash and the scale, holds the biases still to come out
  class bias_scoreboard;
    localparam logic [63:0] FNV_PRIME64 = 64'd1099511628211;
    localparam longint SPAN      = 16777215;
    localparam longint HALF_SPAN = 8388607;
    localparam longint OUT_MAX   = 8388607;
    localparam longint OUT_MIN   = -8388608;

    logic [63:0]         hash;
    logic signed [23:0]  scale;
    phbg_pkg::res_item_t expected_q[$];
    int                  errors;

    function new();
      hash   = phbg_pkg::FNV_BASIS;
      scale  = phbg_pkg::SCALE_RESET;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Step the xorshift, mix, scale the centred unit and round to nearest
    function phbg_pkg::res_item_t next_bias();
      logic [63:0]         s;
      logic [63:0]         mixed;
      longint              centred;
      longint              prod;
      longint              mag;
      longint              q;
      phbg_pkg::res_item_t r;
      s = hash;
      s = s ^ (s >> 12);
      s = s ^ (s << 25);
      s = s ^ (s >> 27);
      hash = s;
      mixed = s * phbg_pkg::XS_MULT;
      r.unit_raw = mixed[63:40];
      centred = 2 * longint'(r.unit_raw) - SPAN;
      prod = centred * longint'(scale);
      mag = (prod < 0) ? -prod : prod;
      q = (mag + HALF_SPAN) / SPAN;
      if (prod < 0) q = -q;
      // only unit_raw == 0 with the most negative scale gets here
      if (q > OUT_MAX) q = OUT_MAX;
      if (q < OUT_MIN) q = OUT_MIN;
      r.bias_value = q[23:0];
      return r;
    endfunction

    task note_item(input phbg_pkg::req_item_t it);
      phbg_pkg::res_item_t r;
      case (it.func)
        phbg_pkg::FUNC_RESTART: hash = phbg_pkg::FNV_BASIS;
        phbg_pkg::FUNC_ABSORB:  hash = (hash ^ {56'd0, it.prompt_byte}) * FNV_PRIME64;
        phbg_pkg::FUNC_EMIT: begin
          r = next_bias();
          expected_q = {expected_q, r};
        end
        default: ;
      endcase
    endtask

    task report(input string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH: %s", msg);
    endtask

    task check_result(input phbg_pkg::res_item_t got);
      phbg_pkg::res_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: bias %0d unit %0d",
                         got.bias_value, got.unit_raw));
        return;
      end
      want = expected_q.pop_front();
      if (got.bias_value !== want.bias_value)
        report($sformatf("bias_value %0d, expected %0d (unit %0d)",
                         got.bias_value, want.bias_value, want.unit_raw));
      if (got.unit_raw !== want.unit_raw)
        report($sformatf("unit_raw %0d, expected %0d", got.unit_raw, want.unit_raw));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  phbg_pkg::req_item_t   req_data = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  phbg_pkg::res_item_t   res_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [phbg_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  bias_scoreboard sb = new();
  bit  hold_request = 1'b0;
  int  phase_items = 0;
  int  send_quiet = 0;
  int  idle_cycles = 0;

  prompt_hash_bias_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** prompt_hash_bias_generator: FAILED **");
      $finish;
    end
  end

  function phbg_pkg::req_item_t make_item(input logic [1:0] func, input logic [7:0] data);
    phbg_pkg::req_item_t it;
    it.func        = func;
    it.prompt_byte = data;
    return it;
  endfunction

  // Offer one item after a random gap, return at the edge that takes it
  task send_item(input phbg_pkg::req_item_t it);
    int gap;
    if (send_quiet > 0) begin
      send_quiet--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 29) == 0) send_quiet = $urandom_range(15, 50);
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_item(it);
    if (it.func != phbg_pkg::FUNC_NONE) phase_items++;
  endtask

  // Stop offering, wait for every bias, then let the queue run dry
  task wait_drained();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of bias_scale followed by a read back
  task program_scale(input logic [23:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SCALE_ADDR;
    pwdata  <= {{8{v[23]}}, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.scale = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[23:0] !== v)
      sb.report($sformatf("bias_scale reads %0h, wrote %0h", prdata[23:0], v));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task scale_burst(input logic [23:0] v);
    wait_drained();
    program_scale(v);
    send_item(make_item(phbg_pkg::FUNC_EMIT, 8'h00));
    send_item(make_item(phbg_pkg::FUNC_EMIT, 8'hFF));
  endtask

  // Mostly prompt-like runs: optional restart, some bytes, some emits
  task send_random_sequence();
    int n_absorb;
    int n_emit;
    if ($urandom_range(0, 99) < 8) begin
      // noise: unused selector, or any item at all
      if ($urandom_range(0, 1) == 0)
        send_item(make_item(phbg_pkg::FUNC_NONE, 8'($urandom)));
      else
        send_item(make_item(2'($urandom), 8'($urandom)));
      return;
    end
    n_absorb = $urandom_range(0, 6);
    n_emit   = $urandom_range(1, 6);
    if ($urandom_range(0, 3) == 0)
      send_item(make_item(phbg_pkg::FUNC_RESTART, 8'($urandom)));
    repeat (n_absorb) send_item(make_item(phbg_pkg::FUNC_ABSORB, 8'($urandom)));
    repeat (n_emit) send_item(make_item(phbg_pkg::FUNC_EMIT, 8'($urandom)));
  endtask

  // Result side: random gaps, one long hold-off on request
  initial begin : result_sink
    int gap;
    int quiet;
    quiet = 0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (quiet > 0) begin
        quiet--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 29) == 0) quiet = $urandom_range(15, 50);
      end
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      sb.check_result(res_data);
    end
  end

  // Stimulus: directed items, then random phases at several scales
  initial begin : stimulus
    logic [23:0] phase_scale;
    int          target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset scale, emits straight from the offset basis, byte extremes,
    // unused selector, restart with a nonzero byte
    send_item(make_item(phbg_pkg::FUNC_EMIT, 8'h00));
    send_item(make_item(phbg_pkg::FUNC_EMIT, 8'hFF));
    send_item(make_item(phbg_pkg::FUNC_ABSORB, 8'h00));
    send_item(make_item(phbg_pkg::FUNC_ABSORB, 8'hFF));
    send_item(make_item(phbg_pkg::FUNC_EMIT, 8'h00));
    send_item(make_item(phbg_pkg::FUNC_NONE, 8'hFF));
    send_item(make_item(phbg_pkg::FUNC_EMIT, 8'hA5));
    send_item(make_item(phbg_pkg::FUNC_RESTART, 8'hFF));
    send_item(make_item(phbg_pkg::FUNC_ABSORB, 8'h80));
    send_item(make_item(phbg_pkg::FUNC_ABSORB, 8'h7F));
    send_item(make_item(phbg_pkg::FUNC_EMIT, 8'h5A));

    // scale extremes, zero and the smallest steps
    scale_burst(SCALE_MAX);
    scale_burst(SCALE_MIN);
    scale_burst(24'h00_0000);
    scale_burst(24'hFF_FFFF);
    scale_burst(24'h00_0001);

    target = RANDOM_ITEMS / RANDOM_PHASES;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       phase_scale = 24'($urandom);
        1:       phase_scale = SCALE_MIN;
        2:       phase_scale = 24'($urandom_range(0, 511));
        3:       phase_scale = SCALE_MAX;
        default: phase_scale = phbg_pkg::SCALE_RESET;
      endcase
      wait_drained();
      program_scale(phase_scale);
      // receiver stalls while items keep coming, so the queue backs up
      if (p == 1) hold_request = 1'b1;
      phase_items = 0;
      while (phase_items < target) send_random_sequence();
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("** prompt_hash_bias_generator: PASSED **");
    end else begin
      $display("** prompt_hash_bias_generator: FAILED **");
    end
    $finish;
  end

endmodule
